// ===== hdl/ckd_pkg.sv =====
// Package for the chord keypad decoder: matrix geometry, virtual key codes,
// event slot positions and the command type passed from front to back.
// No dependencies.
package ckd_pkg;

  localparam int unsigned MatrixRows = 6;
  localparam int unsigned MatrixCols = 3;
  localparam int unsigned VRows      = 2 * MatrixRows - 1;
  localparam int unsigned VCols      = 2 * MatrixCols - 1;

  localparam int unsigned BitmapW = MatrixRows * MatrixCols;
  localparam int unsigned CodeW   = 6;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned VRowW   = $clog2(VRows);
  localparam int unsigned VColW   = $clog2(VCols);

  localparam logic [CodeW-1:0] ShiftCode = CodeW'(3 * VRows + 1);
  localparam logic [CodeW-1:0] CtrlCode  = CodeW'(1);

  localparam logic [VRowW-1:0] ModeRow  = VRowW'(VRows - 1);
  localparam logic [VRowW-1:0] ShiftRow = VRowW'(1);
  localparam logic [VColW-1:0] ShiftCol = VColW'(3);
  localparam logic [VRowW-1:0] CtrlRow  = VRowW'(1);
  localparam logic [VColW-1:0] CtrlCol  = VColW'(0);

  // Event slots of one ordinary key, in emission order.
  localparam int unsigned NumSlots     = 6;
  localparam int unsigned SlotShiftDn  = 0;
  localparam int unsigned SlotCtrlDn   = 1;
  localparam int unsigned SlotKeyDn    = 2;
  localparam int unsigned SlotKeyUp    = 3;
  localparam int unsigned SlotShiftUp  = 4;
  localparam int unsigned SlotCtrlUp   = 5;

  localparam int unsigned CmdQDepth = 2;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             shift;
    logic             ctrl;
    logic [ModeW-1:0] mode;
  } cmd_t;

endpackage

// ===== hdl/ckd_front.sv =====
// Front end of the chord keypad decoder: finds the winning virtual key of a
// sample, keeps mode, shift, caps and ctrl state, and issues key commands.
// Depends on ckd_pkg.
module ckd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [ckd_pkg::BitmapW-1:0]   key_bitmap_i,
  output logic                          cmd_push_o,
  output ckd_pkg::cmd_t                 cmd_o
);

  localparam int unsigned Rows = ckd_pkg::MatrixRows;
  localparam int unsigned Cols = ckd_pkg::MatrixCols;

  logic [ckd_pkg::ModeW-1:0] pad_mode_q, pad_mode_d;
  logic                      shift_q, shift_d;
  logic                      caps_q, caps_d;
  logic                      ctrl_q, ctrl_d;

  // Real matrix with a released border so edge keys see no wrap.
  logic [Rows+1:0][Cols+1:0]                          pad;
  logic [ckd_pkg::VRows-1:0][ckd_pkg::VCols-1:0]      hit_map;
  logic                                               hit;
  logic [ckd_pkg::VRowW-1:0]                          hit_i;
  logic [ckd_pkg::VColW-1:0]                          hit_j;
  logic                                               is_mode, is_shift, is_ctrl;

  always_comb begin
    pad = '0;
    for (int r = 0; r < Rows; r++) begin
      for (int c = 0; c < Cols; c++) begin
        pad[r+1][c+1] = key_bitmap_i[c*Rows+r];
      end
    end
  end

  for (genvar gi = 0; gi < ckd_pkg::VRows; gi++) begin : g_vrow
    for (genvar gj = 0; gj < ckd_pkg::VCols; gj++) begin : g_vcol
      localparam int R0 = gi / 2 + 1;
      localparam int C0 = gj / 2 + 1;
      localparam int RA = (gi - 1) / 2 + 1;
      localparam int RB = (gi + 1) / 2 + 1;
      localparam int CA = (gj - 1) / 2 + 1;
      localparam int CB = (gj + 1) / 2 + 1;
      if ((gi % 2 == 0) && (gj % 2 == 0)) begin : g_real
        assign hit_map[gi][gj] = pad[R0][C0] &
            !(pad[R0-1][C0-1] | pad[R0-1][C0] | pad[R0-1][C0+1] |
              pad[R0][C0-1]   | pad[R0][C0+1] |
              pad[R0+1][C0-1] | pad[R0+1][C0] | pad[R0+1][C0+1]);
      end else if (gj % 2 == 0) begin : g_vert
        assign hit_map[gi][gj] = pad[RA][C0] & pad[RB][C0];
      end else if (gi % 2 == 0) begin : g_horz
        assign hit_map[gi][gj] = pad[R0][CA] & pad[R0][CB];
      end else begin : g_diag
        assign hit_map[gi][gj] = (pad[RA][CA] & pad[RB][CB]) |
                                 (pad[RA][CB] & pad[RB][CA]);
      end
    end
  end

  // Row-major priority: scanning backwards leaves the first hit in place.
  always_comb begin
    hit   = 1'b0;
    hit_i = '0;
    hit_j = '0;
    for (int i = ckd_pkg::VRows - 1; i >= 0; i--) begin
      for (int j = ckd_pkg::VCols - 1; j >= 0; j--) begin
        if (hit_map[i][j]) begin
          hit   = 1'b1;
          hit_i = ckd_pkg::VRowW'(i);
          hit_j = ckd_pkg::VColW'(j);
        end
      end
    end
  end

  assign is_mode  = (hit_i == ckd_pkg::ModeRow);
  assign is_shift = (hit_i == ckd_pkg::ShiftRow) && (hit_j == ckd_pkg::ShiftCol);
  assign is_ctrl  = (hit_i == ckd_pkg::CtrlRow) && (hit_j == ckd_pkg::CtrlCol);

  always_comb begin
    pad_mode_d = pad_mode_q;
    shift_d    = shift_q;
    caps_d     = caps_q;
    ctrl_d     = ctrl_q;
    cmd_push_o = 1'b0;
    if (accept_i && hit) begin
      if (is_mode) begin
        pad_mode_d = ckd_pkg::ModeW'(hit_j >> 1);
      end else if (is_shift) begin
        if (!shift_q) begin
          shift_d = 1'b1;
        end else if (!caps_q) begin
          caps_d = 1'b1;
        end else begin
          shift_d = 1'b0;
          caps_d  = 1'b0;
        end
      end else if (is_ctrl) begin
        ctrl_d = 1'b1;
      end else begin
        cmd_push_o = 1'b1;
        shift_d    = shift_q & caps_q;
        ctrl_d     = 1'b0;
      end
    end
  end

  assign cmd_o.code  = ckd_pkg::CodeW'(hit_j) * ckd_pkg::CodeW'(ckd_pkg::VRows)
                     + ckd_pkg::CodeW'(hit_i);
  assign cmd_o.shift = shift_q;
  assign cmd_o.ctrl  = ctrl_q;
  assign cmd_o.mode  = pad_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_mode_q <= '0;
      shift_q    <= 1'b0;
      caps_q     <= 1'b0;
      ctrl_q     <= 1'b0;
    end else begin
      pad_mode_q <= pad_mode_d;
      shift_q    <= shift_d;
      caps_q     <= caps_d;
      ctrl_q     <= ctrl_d;
    end
  end

`ifndef SYNTH
  // From reset, caps lock is only ever set on top of shift.
  a_caps_needs_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    caps_q |-> shift_q) else $error("caps set without shift");
`endif

endmodule

// ===== hdl/ckd_cmdq.sv =====
// Short command queue between the front and back of the keypad decoder.
// Depends on ckd_pkg.
module ckd_cmdq #(
  parameter int unsigned Depth = ckd_pkg::CmdQDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ckd_pkg::cmd_t data_i,
  input  logic          pop_i,
  output ckd_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ckd_pkg::cmd_t         mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("command queue overfilled");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("command queue pointers disagree with count");
`endif

endmodule

// ===== hdl/ckd_back.sv =====
// Back end of the keypad decoder: expands each key command into its press and
// release events and holds the oldest event in the output register.
// Depends on ckd_pkg.
module ckd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ckd_pkg::cmd_t              cmd_i,
  input  logic                       cmd_empty_i,
  output logic                       cmd_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [ckd_pkg::CodeW-1:0]  scancode_o,
  output logic                       key_down_o,
  output logic                       last_o,
  output logic [ckd_pkg::ModeW-1:0]  mode_o
);

  localparam int unsigned NS = ckd_pkg::NumSlots;

  ckd_pkg::cmd_t               cmd_q, cmd_d;
  logic [NS-1:0]               rem_q, rem_d;
  logic [NS-1:0]               low, rem_after, load_mask;
  logic                        out_valid_q, out_valid_d;
  logic                        out_rdy, emit, load;
  logic [ckd_pkg::CodeW-1:0]   code_q, ev_code;
  logic                        down_q, ev_down;
  logic                        last_q;
  logic [ckd_pkg::ModeW-1:0]   mode_q;

  assign out_rdy = !out_valid_q || pop_i;
  assign emit    = (rem_q != '0) && out_rdy;
  assign low     = rem_q & (~rem_q + 1'b1);
  assign rem_after = emit ? (rem_q & ~low) : rem_q;
  assign load    = (rem_after == '0) && !cmd_empty_i;
  assign cmd_pop_o = load;

  always_comb begin
    load_mask = '0;
    load_mask[ckd_pkg::SlotShiftDn] = cmd_i.shift;
    load_mask[ckd_pkg::SlotCtrlDn]  = cmd_i.ctrl;
    load_mask[ckd_pkg::SlotKeyDn]   = 1'b1;
    load_mask[ckd_pkg::SlotKeyUp]   = 1'b1;
    load_mask[ckd_pkg::SlotShiftUp] = cmd_i.shift;
    load_mask[ckd_pkg::SlotCtrlUp]  = cmd_i.ctrl;
  end

  assign rem_d = load ? load_mask : rem_after;
  assign cmd_d = load ? cmd_i : cmd_q;
  assign out_valid_d = emit || (out_valid_q && !pop_i);

  always_comb begin
    ev_code = cmd_q.code;
    ev_down = 1'b0;
    case (1'b1)
      low[ckd_pkg::SlotShiftDn]: begin
        ev_code = ckd_pkg::ShiftCode;
        ev_down = 1'b1;
      end
      low[ckd_pkg::SlotCtrlDn]: begin
        ev_code = ckd_pkg::CtrlCode;
        ev_down = 1'b1;
      end
      low[ckd_pkg::SlotKeyDn]: begin
        ev_down = 1'b1;
      end
      low[ckd_pkg::SlotShiftUp]: begin
        ev_code = ckd_pkg::ShiftCode;
      end
      low[ckd_pkg::SlotCtrlUp]: begin
        ev_code = ckd_pkg::CtrlCode;
      end
      default: begin
        ev_code = cmd_q.code;
        ev_down = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (emit) begin
      code_q <= ev_code;
      down_q <= ev_down;
      last_q <= ((rem_q & ~low) == '0);
      mode_q <= cmd_q.mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty_o    = !out_valid_q;
  assign scancode_o = code_q;
  assign key_down_o = down_q;
  assign last_o     = last_q;
  assign mode_o     = mode_q;

`ifndef SYNTH
  // While the key press is still pending, so is its release.
  a_keyup_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q[ckd_pkg::SlotKeyDn] |-> rem_q[ckd_pkg::SlotKeyUp]) else $error("key release lost");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (rem_after == '0)) else $error("command fetched while busy");
`endif

endmodule

// ===== hdl/chord_keypad_decoder.sv =====
// Top level of the chord keypad decoder: front classifier, command queue and
// event expander. Depends on ckd_pkg, ckd_front, ckd_cmdq and ckd_back.
//
// Usage. Samples of the 6x3 key matrix enter through a queue-like port:
// a sample is taken at a clock edge where push is high and full is low.
// Events leave through a second queue-like port: while empty is low the
// oldest event sits on scancode_o, key_down_o, last_o and mode_o, and it is
// taken at an edge where pop is high. last_o marks the final event of one
// sample's run.
// Timing. A sample is classified in the cycle it is taken; mode, shift and
// ctrl keys only change state and produce no events. An ordinary key becomes
// a command in the queue; it passes through the queue and the expander's
// command register before its first event reaches the output register. The
// expander then delivers one event per cycle while pop keeps up, two to six
// events per key; this sets the sustained rate, six with shift and ctrl armed.
// Up to CmdQDepth commands wait in the queue; full rises when it is full.
// Stalling. If pop stays low the event waits, the expander holds, the queue
// fills and full rises; nothing is dropped.
// Reset. Asynchronous, active low: alpha mode, shift, caps and ctrl clear,
// the queue and the output are empty.
module chord_keypad_decoder #(
  parameter int unsigned CmdQDepth = ckd_pkg::CmdQDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [ckd_pkg::BitmapW-1:0]   key_bitmap_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [ckd_pkg::CodeW-1:0]     scancode_o,
  output logic                          key_down_o,
  output logic                          last_o,
  output logic [ckd_pkg::ModeW-1:0]     mode_o
);

  logic          accept;
  logic          cmd_push;
  ckd_pkg::cmd_t cmd_in;
  ckd_pkg::cmd_t cmd_head;
  logic          cmd_pop;
  logic          cmd_empty;

  // A sample is taken whenever the queue has room, even when it only
  // changes state, so a full queue stalls all samples in order.
  assign accept = push && !full;

  ckd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .key_bitmap_i (key_bitmap_i),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  ckd_cmdq #(
    .Depth (CmdQDepth)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .full_o  (full),
    .empty_o (cmd_empty)
  );

  ckd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .scancode_o  (scancode_o),
    .key_down_o  (key_down_o),
    .last_o      (last_o),
    .mode_o      (mode_o)
  );

endmodule
